FILE: design/gregorian_date_arithmetic_defines.svh
// ----------------------------------------------------------------------------
// gregorian date arithmetic assertion macros
// shared property forms for the date unit checks
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ARITHMETIC_DEFINES_SVH
`define GREGORIAN_DATE_ARITHMETIC_DEFINES_SVH

// same-cycle implication
`define GDA_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GDA_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg
// types, codes, constants and calendar helpers of the date unit
// ----------------------------------------------------------------------------
`default_nettype none

package gda_pkg;

   localparam int MAX_YEAR_DEF = 9999;

   localparam logic [1:0] REQ_SHIFT   = 2'd0;
   localparam logic [1:0] REQ_DIFF    = 2'd1;
   localparam logic [1:0] REQ_CMP     = 2'd2;
   localparam logic [1:0] REQ_CMP_ALT = 2'd3;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_YEAR  = 3'd1;
   localparam logic [2:0] ST_MONTH = 3'd2;
   localparam logic [2:0] ST_DAY   = 3'd3;
   localparam logic [2:0] ST_RANGE = 3'd4;

   localparam logic [1:0] ORD_LESS    = 2'd0;
   localparam logic [1:0] ORD_EQUAL   = 2'd1;
   localparam logic [1:0] ORD_GREATER = 2'd2;

   localparam int D400 = 146097;
   localparam int D100 = 36524;
   localparam int D4   = 1461;
   localparam int D1   = 365;

   localparam longint unsigned K400 = ((64'd1 << 43) + 64'd146096) / 64'd146097;
   localparam longint unsigned K4   = ((64'd1 << 27) + 64'd1460) / 64'd1461;
   localparam int unsigned     K100 = 5243;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [22:0] diff;
      logic [1:0]         ord;
      logic               date_ok;
   } res_type;

   function automatic logic [7:0] div100(input logic [13:0] v);
      logic [26:0] pr;
      pr = 27'(v) * 27'(K100);
      return pr[26:19];
   endfunction

   function automatic logic is_leap(input logic [1:0] ylow, input logic [7:0] qy,
                                    input logic [7:0] qp);
      return (ylow == 2'd0) && ((qy == qp) || (qy[1:0] == 2'd0));
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd2:                     len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
         default:                  len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
      logic [8:0] c;
      case (m)
         4'd2:    c = 9'd31;
         4'd3:    c = 9'd59;
         4'd4:    c = 9'd90;
         4'd5:    c = 9'd120;
         4'd6:    c = 9'd151;
         4'd7:    c = 9'd181;
         4'd8:    c = 9'd212;
         4'd9:    c = 9'd243;
         4'd10:   c = 9'd273;
         4'd11:   c = 9'd304;
         4'd12:   c = 9'd334;
         default: c = 9'd0;
      endcase
      if (leap && (m > 4'd2) && (m <= 4'd12)) begin
         c = c + 9'd1;
      end
      return c;
   endfunction

   function automatic logic [2:0] check_date(input logic [4:0] d, input logic [3:0] m,
                                             input logic [13:0] y, input logic leap,
                                             input logic [16:0] maxy);
      logic [2:0] st;
      if ((y == 14'd0) || (17'(y) > maxy)) begin
         st = ST_YEAR;
      end else if ((m == 4'd0) || (m > 4'd12)) begin
         st = ST_MONTH;
      end else if ((d == 5'd0) || (d > month_len(m, leap))) begin
         st = ST_DAY;
      end else begin
         st = ST_OK;
      end
      return st;
   endfunction

endpackage

`default_nettype wire

FILE: design/gregorian_date_arithmetic.sv
// throughput: one item per cycle while rsp_ready holds, each stage holds its item while the next stage is stalled
// stages: year division, serial day, add/compare, then 400/100/4/1-year and month
// reset: synchronous, clears the stage valid bits only
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic
// proleptic gregorian date shift, day difference and compare, pipelined
// ----------------------------------------------------------------------------
`default_nettype none

`include "gregorian_date_arithmetic_defines.svh"

module gregorian_date_arithmetic
   import gda_pkg::*;
#(
   parameter int MAX_YEAR = MAX_YEAR_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire  [1:0]         req_type,
   input  wire  [4:0]         req_day_a,
   input  wire  [3:0]         req_month_a,
   input  wire  [13:0]        req_year_a,
   input  wire  [4:0]         req_day_b,
   input  wire  [3:0]         req_month_b,
   input  wire  [13:0]        req_year_b,
   input  wire  signed [22:0] req_day_offset,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic [4:0]         rsp_day_r,
   output logic [3:0]         rsp_month_r,
   output logic [13:0]        rsp_year_r,
   output logic signed [22:0] rsp_diff_days,
   output logic [1:0]         rsp_order,
   output logic [2:0]         rsp_status
);

   localparam logic [16:0] MAXY = 17'(MAX_YEAR);
   localparam int TOP = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;

   logic [10:1] v_ff, v_in, en;

   always_comb begin
      en[10] = !v_ff[10] || rsp_ready;
      for (int k = 9; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k + 1];
      end
      v_in = (en & {v_ff[9:1], req_valid}) | (~en & v_ff);
   end

   assign req_ready = en[1];
   assign rsp_valid = v_ff[10];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // stage 1: year divisions
   logic [1:0]         s1_type_ff;
   logic [4:0]         s1_da_ff, s1_db_ff;
   logic [3:0]         s1_ma_ff, s1_mb_ff;
   logic [13:0]        s1_ya_ff, s1_yb_ff;
   logic signed [22:0] s1_off_ff;
   logic [7:0]         s1_qya_ff, s1_qpa_ff, s1_qyb_ff, s1_qpb_ff;
   logic [22:0]        s1_p365a_ff, s1_p365b_ff;
   logic [13:0]        pa, pb;

   assign pa = req_year_a - 14'd1;
   assign pb = req_year_b - 14'd1;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_type_ff  <= req_type;
         s1_da_ff    <= req_day_a;
         s1_ma_ff    <= req_month_a;
         s1_ya_ff    <= req_year_a;
         s1_db_ff    <= req_day_b;
         s1_mb_ff    <= req_month_b;
         s1_yb_ff    <= req_year_b;
         s1_off_ff   <= req_day_offset;
         s1_qya_ff   <= div100(req_year_a);
         s1_qpa_ff   <= div100(pa);
         s1_qyb_ff   <= div100(req_year_b);
         s1_qpb_ff   <= div100(pb);
         s1_p365a_ff <= 23'(pa) * 23'(D1);
         s1_p365b_ff <= 23'(pb) * 23'(D1);
      end
   end

   // stage 2: checks and serial day numbers
   logic               leap_a, leap_b;
   logic [13:0]        p2a, p2b;
   logic [23:0]        sa_in, sb_in;
   logic [2:0]         st2_in;
   logic [1:0]         s2_type_ff;
   logic signed [22:0] s2_off_ff;
   logic [23:0]        s2_sa_ff, s2_sb_ff;
   logic [2:0]         s2_status_ff;

   always_comb begin
      leap_a = is_leap(s1_ya_ff[1:0], s1_qya_ff, s1_qpa_ff);
      leap_b = is_leap(s1_yb_ff[1:0], s1_qyb_ff, s1_qpb_ff);
      p2a    = s1_ya_ff - 14'd1;
      p2b    = s1_yb_ff - 14'd1;
      sa_in  = 24'(s1_p365a_ff) + 24'(p2a >> 2) - 24'(s1_qpa_ff) + 24'(s1_qpa_ff >> 2)
             + 24'(cum_days(s1_ma_ff, leap_a)) + 24'(s1_da_ff);
      sb_in  = 24'(s1_p365b_ff) + 24'(p2b >> 2) - 24'(s1_qpb_ff) + 24'(s1_qpb_ff >> 2)
             + 24'(cum_days(s1_mb_ff, leap_b)) + 24'(s1_db_ff);
      st2_in = check_date(s1_da_ff, s1_ma_ff, s1_ya_ff, leap_a, MAXY);
      if ((st2_in == ST_OK) && (s1_type_ff != REQ_SHIFT)) begin
         st2_in = check_date(s1_db_ff, s1_mb_ff, s1_yb_ff, leap_b, MAXY);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_type_ff   <= s1_type_ff;
         s2_off_ff    <= s1_off_ff;
         s2_sa_ff     <= sa_in;
         s2_sb_ff     <= sb_in;
         s2_status_ff <= st2_in;
      end
   end

   // stage 3: shift, difference, compare
   logic signed [25:0] sum, dif;
   res_type            res3_in, s3_res_ff;
   logic [24:0]        n_in, s3_n_ff;

   always_comb begin
      sum = signed'({2'b00, s2_sa_ff}) + 26'(s2_off_ff);
      dif = signed'({2'b00, s2_sa_ff}) - signed'({2'b00, s2_sb_ff});
      res3_in.status  = s2_status_ff;
      res3_in.diff    = '0;
      res3_in.ord     = ORD_LESS;
      res3_in.date_ok = 1'b0;
      n_in            = '0;
      if (s2_status_ff == ST_OK) begin
         case (s2_type_ff)
            REQ_SHIFT: begin
               if ((sum < 26'sd1) || (sum > signed'(26'(TOP)))) begin
                  res3_in.status = ST_RANGE;
               end else begin
                  res3_in.date_ok = 1'b1;
                  n_in            = 25'(sum - 26'sd1);
               end
            end
            REQ_DIFF: begin
               if ((dif < -26'sd4194304) || (dif > 26'sd4194303)) begin
                  res3_in.status = ST_RANGE;
               end else begin
                  res3_in.diff = 23'(dif);
               end
            end
            default: begin
               if (s2_sa_ff < s2_sb_ff) begin
                  res3_in.ord = ORD_LESS;
               end else if (s2_sa_ff == s2_sb_ff) begin
                  res3_in.ord = ORD_EQUAL;
               end else begin
                  res3_in.ord = ORD_GREATER;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_res_ff <= res3_in;
         s3_n_ff   <= n_in;
      end
   end

   // stage 4: 400-year quotient
   logic [50:0] prod400;
   res_type     s4_res_ff;
   logic [24:0] s4_n_ff;
   logic [7:0]  s4_q400_ff;

   assign prod400 = 51'(s3_n_ff) * 51'(K400);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_res_ff  <= s3_res_ff;
         s4_n_ff    <= s3_n_ff;
         s4_q400_ff <= prod400[50:43];
      end
   end

   // stage 5: 400-year remainder
   res_type     s5_res_ff;
   logic [7:0]  s5_q400_ff;
   logic [17:0] s5_r400_ff;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_res_ff  <= s4_res_ff;
         s5_q400_ff <= s4_q400_ff;
         s5_r400_ff <= 18'(s4_n_ff - 25'(s4_q400_ff) * 25'(D400));
      end
   end

   // stage 6: century step
   logic [1:0]  q100_in;
   logic [15:0] r100_in;
   res_type     s6_res_ff;
   logic [7:0]  s6_q400_ff;
   logic [1:0]  s6_q100_ff;
   logic [15:0] s6_r100_ff;

   always_comb begin
      if (s5_r400_ff >= 18'(3 * D100)) begin
         q100_in = 2'd3;
         r100_in = 16'(s5_r400_ff - 18'(3 * D100));
      end else if (s5_r400_ff >= 18'(2 * D100)) begin
         q100_in = 2'd2;
         r100_in = 16'(s5_r400_ff - 18'(2 * D100));
      end else if (s5_r400_ff >= 18'(D100)) begin
         q100_in = 2'd1;
         r100_in = 16'(s5_r400_ff - 18'(D100));
      end else begin
         q100_in = 2'd0;
         r100_in = 16'(s5_r400_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s6_res_ff  <= s5_res_ff;
         s6_q400_ff <= s5_q400_ff;
         s6_q100_ff <= q100_in;
         s6_r100_ff <= r100_in;
      end
   end

   // stage 7: 4-year quotient
   logic [33:0] prod4;
   res_type     s7_res_ff;
   logic [7:0]  s7_q400_ff;
   logic [1:0]  s7_q100_ff;
   logic [15:0] s7_r100_ff;
   logic [4:0]  s7_q4_ff;

   assign prod4 = 34'(s6_r100_ff) * 34'(K4);

   always_ff @(posedge clock) begin
      if (en[7]) begin
         s7_res_ff  <= s6_res_ff;
         s7_q400_ff <= s6_q400_ff;
         s7_q100_ff <= s6_q100_ff;
         s7_r100_ff <= s6_r100_ff;
         s7_q4_ff   <= prod4[31:27];
      end
   end

   // stage 8: 4-year remainder
   res_type     s8_res_ff;
   logic [7:0]  s8_q400_ff;
   logic [1:0]  s8_q100_ff;
   logic [4:0]  s8_q4_ff;
   logic [10:0] s8_r4_ff;

   always_ff @(posedge clock) begin
      if (en[8]) begin
         s8_res_ff  <= s7_res_ff;
         s8_q400_ff <= s7_q400_ff;
         s8_q100_ff <= s7_q100_ff;
         s8_q4_ff   <= s7_q4_ff;
         s8_r4_ff   <= 11'(s7_r100_ff - 16'(s7_q4_ff) * 16'(D4));
      end
   end

   // stage 9: single years, year number
   logic [1:0]  q1;
   logic [8:0]  r1_in;
   logic [16:0] year_in;
   res_type     s9_res_ff;
   logic [13:0] s9_year_ff;
   logic [8:0]  s9_r1_ff;
   logic        s9_leap_ff;

   always_comb begin
      if (s8_r4_ff >= 11'(3 * D1)) begin
         q1    = 2'd3;
         r1_in = 9'(s8_r4_ff - 11'(3 * D1));
      end else if (s8_r4_ff >= 11'(2 * D1)) begin
         q1    = 2'd2;
         r1_in = 9'(s8_r4_ff - 11'(2 * D1));
      end else if (s8_r4_ff >= 11'(D1)) begin
         q1    = 2'd1;
         r1_in = 9'(s8_r4_ff - 11'(D1));
      end else begin
         q1    = 2'd0;
         r1_in = 9'(s8_r4_ff);
      end
      year_in = 17'(s8_q400_ff) * 17'd400 + 17'(s8_q100_ff) * 17'd100
              + 17'({s8_q4_ff, 2'b00}) + 17'(q1) + 17'd1;
   end

   always_ff @(posedge clock) begin
      if (en[9]) begin
         s9_res_ff  <= s8_res_ff;
         s9_year_ff <= year_in[13:0];
         s9_r1_ff   <= r1_in;
         s9_leap_ff <= (q1 == 2'd3) && ((s8_q4_ff != 5'd24) || (s8_q100_ff == 2'd3));
      end
   end

   // stage 10: month and day, result register
   logic [3:0] month_in;
   logic [4:0] day_in;

   always_comb begin
      month_in = 4'd1;
      for (int m = 2; m <= 12; m++) begin
         if (cum_days(4'(m), s9_leap_ff) <= s9_r1_ff) begin
            month_in = month_in + 4'd1;
         end
      end
      day_in = 5'(s9_r1_ff - cum_days(month_in, s9_leap_ff) + 9'd1);
   end

   always_ff @(posedge clock) begin
      if (en[10]) begin
         rsp_day_r     <= s9_res_ff.date_ok ? day_in : 5'd0;
         rsp_month_r   <= s9_res_ff.date_ok ? month_in : 4'd0;
         rsp_year_r    <= s9_res_ff.date_ok ? s9_year_ff : 14'd0;
         rsp_diff_days <= s9_res_ff.diff;
         rsp_order     <= s9_res_ff.ord;
         rsp_status    <= s9_res_ff.status;
      end
   end

   `GDA_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && (rsp_status != ST_OK), (rsp_day_r == 5'd0) && (rsp_diff_days == '0) && (rsp_order == ORD_LESS), "error result carries data")
   `GDA_ASSERT_NXT(a_stage_hold, clock, reset, v_ff[1] && !en[1], v_ff[1], "stalled stage lost its item")
   `GDA_ASSERT_IMP(a_r400_range, clock, reset, v_ff[5], s5_r400_ff < 18'(D400), "400-year remainder out of range")
   `GDA_ASSERT_IMP(a_r4_range, clock, reset, v_ff[8], s8_r4_ff < 11'(D4), "4-year remainder out of range")

endmodule

`default_nettype wire

FILE: test/tb_gregorian_date_arithmetic.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gregorian_date_arithmetic
// random and directed date shift, difference and compare requests checked
// against a serial-day calendar predictor, with random idling on both sides
// ----------------------------------------------------------------------------
`default_nettype none

class date_scoreboard;
   typedef struct {
      logic [4:0]         day;
      logic [3:0]         month;
      logic [13:0]        year;
      logic signed [22:0] diff;
      logic [1:0]         ord;
      logic [2:0]         status;
   } date_result_type;

   date_result_type pending_results[$];
   int mismatches;
   int checked;
   int max_year;

   function new(int my);
      max_year = my;
      mismatches = 0;
      checked = 0;
   endfunction

   function bit leap_year(longint y);
      if (y % 400 == 0) return 1;
      if (y % 100 == 0) return 0;
      return (y % 4) == 0;
   endfunction

   function longint days_in_month(longint m, longint y);
      case (m)
         2:             return leap_year(y) ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   function logic [2:0] validate(longint d, longint m, longint y);
      if (y < 1 || y > max_year) return gda_pkg::ST_YEAR;
      if (m < 1 || m > 12) return gda_pkg::ST_MONTH;
      if (d < 1 || d > days_in_month(m, y)) return gda_pkg::ST_DAY;
      return gda_pkg::ST_OK;
   endfunction

   function longint day_number(longint d, longint m, longint y);
      longint p, s;
      p = y - 1;
      s = 365 * p + p / 4 - p / 100 + p / 400;
      for (longint i = 1; i < m; i++) s += days_in_month(i, y);
      return s + d;
   endfunction

   function void note_request(logic [1:0] rt, logic [4:0] da, logic [3:0] ma,
                              logic [13:0] ya, logic [4:0] db, logic [3:0] mb,
                              logic [13:0] yb, logic signed [22:0] off);
      date_result_type r;
      logic [2:0] st;
      longint sa, sb, s, top, y, d;
      r = '{default: 0};
      st = validate(da, ma, ya);
      if (st == gda_pkg::ST_OK && rt != gda_pkg::REQ_SHIFT) st = validate(db, mb, yb);
      if (st != gda_pkg::ST_OK) begin
         r.status = st;
      end else begin
         sa = day_number(da, ma, ya);
         if (rt == gda_pkg::REQ_SHIFT) begin
            s = sa + longint'(off);
            top = day_number(31, 12, max_year);
            if (s < 1 || s > top) begin
               r.status = gda_pkg::ST_RANGE;
            end else begin
               y = 1;
               while (day_number(1, 1, y + 400) <= s) y += 400;
               while (day_number(1, 1, y + 1) <= s) y += 1;
               d = s - day_number(1, 1, y);
               r.month = 4'd1;
               while (r.month < 12 && d >= days_in_month(r.month, y)) begin
                  d -= days_in_month(r.month, y);
                  r.month++;
               end
               r.day = 5'(d + 1);
               r.year = 14'(y);
            end
         end else begin
            sb = day_number(db, mb, yb);
            if (rt == gda_pkg::REQ_DIFF) begin
               if (sa - sb < -4194304 || sa - sb > 4194303) r.status = gda_pkg::ST_RANGE;
               else r.diff = 23'(sa - sb);
            end else begin
               r.ord = (sa < sb) ? gda_pkg::ORD_LESS :
                       (sa == sb) ? gda_pkg::ORD_EQUAL : gda_pkg::ORD_GREATER;
            end
         end
      end
      pending_results.push_back(r);
   endfunction

   function void check_result(logic [4:0] d, logic [3:0] m, logic [13:0] y,
                              logic signed [22:0] df, logic [1:0] o, logic [2:0] st);
      date_result_type e;
      checked++;
      if (pending_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result transfer st=%0d", st);
         return;
      end
      e = pending_results.pop_front();
      if (e.day !== d || e.month !== m || e.year !== y || e.diff !== df ||
          e.ord !== o || e.status !== st) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch exp %0d-%0d-%0d diff=%0d ord=%0d st=%0d /%s",
                     e.year, e.month, e.day, e.diff, e.ord, e.status,
                     $sformatf(" got %0d-%0d-%0d diff=%0d ord=%0d st=%0d",
                               y, m, d, df, o, st));
      end
   endfunction
endclass

module tb_gregorian_date_arithmetic;
   import gda_pkg::*;

   localparam int N_RANDOM = 650;
   localparam int WATCHDOG = 20000;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [1:0]         req_type = 0;
   logic [4:0]         req_day_a = 1;
   logic [3:0]         req_month_a = 1;
   logic [13:0]        req_year_a = 1;
   logic [4:0]         req_day_b = 1;
   logic [3:0]         req_month_b = 1;
   logic [13:0]        req_year_b = 1;
   logic signed [22:0] req_day_offset = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [4:0]         rsp_day_r;
   logic [3:0]         rsp_month_r;
   logic [13:0]        rsp_year_r;
   logic signed [22:0] rsp_diff_days;
   logic [1:0]         rsp_order;
   logic [2:0]         rsp_status;

   date_scoreboard calendar_check = new(MAX_YEAR_DEF);
   bit  idle_enable = 1;
   int  quiet_cycles = 0;
   bit  timed_out = 0;
   int  n_sent = 0;

   gregorian_date_arithmetic i_dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (rsp_valid && rsp_ready)
         calendar_check.check_result(rsp_day_r, rsp_month_r, rsp_year_r,
                                     rsp_diff_days, rsp_order, rsp_status);
   end

   // receiver side stalls
   initial begin
      int gap;
      @(posedge clock);
      forever begin
         if (idle_enable && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
      end
   end

   task automatic send_request(logic [1:0] rt, logic [4:0] da, logic [3:0] ma,
                               logic [13:0] ya, logic [4:0] db, logic [3:0] mb,
                               logic [13:0] yb, logic signed [22:0] off);
      int gap;
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_type <= rt;
      req_day_a <= da;
      req_month_a <= ma;
      req_year_a <= ya;
      req_day_b <= db;
      req_month_b <= mb;
      req_year_b <= yb;
      req_day_offset <= off;
      do @(posedge clock); while (!req_ready);
      calendar_check.note_request(rt, da, ma, ya, db, mb, yb, off);
      n_sent++;
   endtask

   task automatic send_random();
      logic [1:0] rt;
      logic [4:0] da, db;
      logic [3:0] ma, mb;
      logic [13:0] ya, yb;
      logic signed [22:0] off;
      rt = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) begin
         {da, ma, ya, db, mb, yb} = 46'({$urandom, $urandom});
      end else begin
         ma = 4'($urandom_range(1, 12));
         mb = 4'($urandom_range(1, 12));
         ya = $urandom_range(0, 3) == 0 ? 14'($urandom_range(1, 9999)) :
              14'($urandom_range(0, 24) * 400 + $urandom_range(0, 3) * 100
                  + $urandom_range(0, 99) + 1);
         if (ya > 9999) ya = 9999;
         yb = $urandom_range(0, 1) ? ya + 14'($urandom_range(0, 3)) :
              14'($urandom_range(1, 9999));
         if (yb > 9999) yb = 9999;
         da = 5'($urandom_range(1, (ma == 2) ? 29 : 31));
         db = $urandom_range(0, 3) == 0 ? da : 5'($urandom_range(1, (mb == 2) ? 29 : 31));
      end
      case ($urandom_range(0, 3))
         0:       off = 23'($urandom_range(0, 800) - 400);
         1:       off = 23'($urandom);
         2:       off = 23'($urandom_range(0, 80000) - 40000);
         default: off = 23'($urandom_range(0, 2000000) - 1000000);
      endcase
      send_request(rt, da, ma, ya, db, mb, yb, off);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, leap rules, each fault and out of range
      send_request(REQ_SHIFT, 1, 1, 1, 1, 1, 1, 0);
      send_request(REQ_SHIFT, 1, 1, 1, 1, 1, 1, -1);
      send_request(REQ_SHIFT, 31, 12, 9999, 1, 1, 1, 1);
      send_request(REQ_SHIFT, 31, 12, 9999, 1, 1, 1, 0);
      send_request(REQ_SHIFT, 28, 2, 2000, 1, 1, 1, 1);
      send_request(REQ_SHIFT, 28, 2, 1900, 1, 1, 1, 1);
      send_request(REQ_SHIFT, 1, 1, 1, 1, 1, 1, 23'sh3FFFFF);
      send_request(REQ_SHIFT, 31, 12, 9999, 1, 1, 1, 23'sh400000);
      send_request(REQ_SHIFT, 31, 12, 5000, 1, 1, 1, -23'sd1000);
      send_request(REQ_SHIFT, 1, 1, 0, 1, 1, 1, 0);
      send_request(REQ_SHIFT, 1, 1, 14'h3FFF, 1, 1, 1, 0);
      send_request(REQ_SHIFT, 1, 0, 2024, 1, 1, 1, 0);
      send_request(REQ_SHIFT, 1, 15, 2024, 1, 1, 1, 0);
      send_request(REQ_SHIFT, 0, 3, 2024, 1, 1, 1, 0);
      send_request(REQ_SHIFT, 29, 2, 2023, 1, 1, 1, 0);
      send_request(REQ_SHIFT, 31, 4, 2023, 1, 1, 1, 0);
      send_request(REQ_DIFF, 31, 12, 9999, 1, 1, 1, 0);
      send_request(REQ_DIFF, 1, 1, 1, 31, 12, 9999, 0);
      send_request(REQ_DIFF, 1, 3, 2000, 28, 2, 2000, 0);
      send_request(REQ_DIFF, 1, 1, 2000, 1, 1, 0, 0);
      send_request(REQ_DIFF, 1, 1, 2000, 32 - 1, 2, 2001, 0);
      send_request(REQ_CMP, 1, 1, 2000, 1, 1, 2000, 0);
      send_request(REQ_CMP, 1, 1, 2000, 2, 1, 2000, 0);
      send_request(REQ_CMP_ALT, 2, 1, 2000, 1, 1, 2000, 0);
      send_request(REQ_CMP, 1, 1, 2000, 1, 13, 2000, 0);
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM - 100) idle_enable = 0;
         send_random();
      end
      req_valid <= 0;
   end

   initial begin
      while (!(n_sent >= N_RANDOM + 25 && calendar_check.pending_results.size() == 0)) begin
         @(posedge clock);
         if (quiet_cycles >= WATCHDOG) begin
            timed_out = 1;
            break;
         end
      end
      if (timed_out) begin
         $display("[FAIL] regression broken");
      end else begin
         repeat (40) @(posedge clock);
         $display("covered %0d requests: shifts, differences, compares, bad dates, range edges",
                  n_sent);
         $display("%0d results checked, %0d mismatches", calendar_check.checked,
                  calendar_check.mismatches);
         if (calendar_check.mismatches == 0 && calendar_check.pending_results.size() == 0)
            $display("[ OK ] regression clean");
         else
            $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
